@@ design/psc_pkg.sv @@
`timescale 1ns / 1ps
// psc_pkg: types and constants shared by the pair sum counter modules.
// No dependencies.
package psc_pkg;

  localparam int VAL_W   = 10;
  localparam int TGT_W   = 11;
  localparam int CNT_W   = 11;
  localparam int TOTAL_W = 19;
  localparam int EPOCH_W = 8;

  localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
  localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);

  // One histogram entry: the set it belongs to and its count.
  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic [CNT_W-1:0]   count;
  } hist_entry_t;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } psc_state_t;

  // Controller status seen by the datapath.
  typedef struct packed {
    logic               clearing;
    logic [EPOCH_W-1:0] epoch;
  } psc_ctl_t;

endpackage

@@ design/psc_hist_mem.sv @@
`timescale 1ns / 1ps
// psc_hist_mem: histogram storage, one write port and two registered read ports.
// Depends on psc_pkg.
module psc_hist_mem #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic                  clk,
  input  logic                  rd_en,
  input  logic [ADDR_W-1:0]     rd_a_addr,
  input  logic [ADDR_W-1:0]     rd_b_addr,
  output psc_pkg::hist_entry_t  rd_a_data,
  output psc_pkg::hist_entry_t  rd_b_data,
  input  logic                  wr_en,
  input  logic [ADDR_W-1:0]     wr_addr,
  input  psc_pkg::hist_entry_t  wr_data
);
  import psc_pkg::*;

  hist_entry_t mem [DEPTH];
  hist_entry_t rd_a_r;
  hist_entry_t rd_b_r;

  // Read returns the old contents on a same-address write.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a_r <= mem[rd_a_addr];
      rd_b_r <= mem[rd_b_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign rd_a_data = rd_a_r;
  assign rd_b_data = rd_b_r;

endmodule

@@ design/psc_ctrl.sv @@
`timescale 1ns / 1ps
// psc_ctrl: set epoch counter and histogram clearing sweep.
// Depends on psc_pkg.
module psc_ctrl #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              set_done,
  output logic [ADDR_W-1:0] clr_addr,
  output psc_pkg::psc_ctl_t ctl
);
  import psc_pkg::*;

  psc_state_t         state_r, state_nxt;
  logic [ADDR_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic [EPOCH_W-1:0] epoch_r, epoch_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
      epoch_r   <= EPOCH_FIRST;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      epoch_r   <= epoch_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    epoch_nxt   = epoch_r;
    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == ADDR_W'(DEPTH - 1)) begin
          clr_cnt_nxt = '0;
          state_nxt   = ST_RUN;
        end
      end
      ST_RUN: begin
        if (set_done) begin
          if (epoch_r == EPOCH_MAX) begin
            // tags are about to alias: wipe them all back to zero
            epoch_nxt   = EPOCH_FIRST;
            clr_cnt_nxt = '0;
            state_nxt   = ST_CLEAR;
          end else begin
            epoch_nxt = epoch_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  assign clr_addr     = clr_cnt_r;
  assign ctl.clearing = (state_r == ST_CLEAR);
  assign ctl.epoch    = epoch_r;

endmodule

@@ design/pair_sum_counter.sv @@
`timescale 1ns / 1ps
// pair_sum_counter: counts index pairs of a set whose values sum to target_sum.
// Depends on psc_pkg, psc_hist_mem, psc_ctrl.
//
//  Channel  Ports                          Direction  Transaction
//  in       in_valid/in_stall, in_value,   input      one set element
//           in_last
//  out      out_valid/out_stall,           output     pair count, one per set
//           out_pair_count
//  cfg      cfg_wr_en, cfg_wr_data         input      target_sum write
//
// One input transaction per cycle is sustained while in_stall is low. Each
// element reads the histogram at its own value and at its complement on the
// accepting edge and writes back its incremented count from stage 1; a
// one-deep forward covers back-to-back elements hitting the same entry.
// Sets are told apart by an 8-bit epoch tag stored with each count, so no
// clear is needed between sets. After reset, and after every 255th set, a
// sweep rewrites all VALUE_RANGE entries with in_stall high; before a wrap
// sweep in_stall is also high in the cycle the 255th set leaves the
// pipeline. Reset is synchronous, active low; target_sum resets to 0.
// in_stall also rises while a finished count waits on out_stall and the next
// last element is ready to leave the pipeline.
module pair_sum_counter #(
  parameter int VALUE_RANGE = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [psc_pkg::TGT_W-1:0]     cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [psc_pkg::VAL_W-1:0]     in_value,
  input  logic                          in_last,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [psc_pkg::TOTAL_W-1:0]   out_pair_count
);
  import psc_pkg::*;

  localparam int AW = $clog2(VALUE_RANGE);

  psc_ctl_t          ctl;
  logic [AW-1:0]     clr_addr;

  logic [TGT_W-1:0]  target_r;

  // stage 0 (accept)
  logic              in_acc;
  logic [TGT_W-1:0]  comp;
  logic              v_ok, c_ok;
  logic [AW-1:0]     v_addr, c_addr;

  // stage 1 (update)
  logic              s1_valid_r, s1_last_r, s1_v_ok_r, s1_c_ok_r;
  logic [AW-1:0]     s1_v_addr_r;
  logic              s1_adv, s1_wr;
  hist_entry_t       rd_v, rd_c;
  logic [CNT_W-1:0]  v_cnt, c_cnt, new_cnt;
  logic [TOTAL_W:0]  sum;
  logic [TOTAL_W-1:0] tot_new;
  logic [TOTAL_W-1:0] total_r;

  // forward of the write made on the accepting edge
  logic              fwd_v_r, fwd_c_r;
  logic [CNT_W-1:0]  fwd_cnt_r;

  logic              out_valid_r;
  logic [TOTAL_W-1:0] out_pair_count_r;

  logic              mem_wr_en;
  logic [AW-1:0]     mem_wr_addr;
  hist_entry_t       mem_wr_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
    end else if (cfg_wr_en) begin
      target_r <= cfg_wr_data;
    end
  end

  // ---- stage 0: lookup addresses ----
  assign comp   = target_r - TGT_W'(in_value);
  assign v_ok   = 32'(in_value) < 32'(VALUE_RANGE);
  assign c_ok   = (target_r >= TGT_W'(in_value)) && (32'(comp) < 32'(VALUE_RANGE));
  assign v_addr = AW'(in_value);
  assign c_addr = AW'(comp);

  assign s1_adv = s1_valid_r && !(s1_last_r && out_valid_r && out_stall);
  assign s1_wr  = s1_adv && s1_v_ok_r;

  // hold off while clearing, while stage 1 is blocked, or right before a sweep
  assign in_stall = ctl.clearing || (s1_valid_r && !s1_adv) ||
                    (s1_valid_r && s1_last_r && (ctl.epoch == EPOCH_MAX));
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_last_r   <= in_last;
      s1_v_ok_r   <= v_ok;
      s1_c_ok_r   <= c_ok;
      s1_v_addr_r <= v_addr;
      // a write on this very edge is missed by the memory read
      fwd_v_r     <= s1_wr && !s1_last_r && (s1_v_addr_r == v_addr);
      fwd_c_r     <= s1_wr && !s1_last_r && (s1_v_addr_r == c_addr);
      fwd_cnt_r   <= new_cnt;
    end
  end

  psc_hist_mem #(
    .DEPTH  (VALUE_RANGE),
    .ADDR_W (AW)
  ) u_mem (
    .clk       (clk),
    .rd_en     (in_acc),
    .rd_a_addr (v_addr),
    .rd_b_addr (c_addr),
    .rd_a_data (rd_v),
    .rd_b_data (rd_c),
    .wr_en     (mem_wr_en),
    .wr_addr   (mem_wr_addr),
    .wr_data   (mem_wr_data)
  );

  psc_ctrl #(
    .DEPTH  (VALUE_RANGE),
    .ADDR_W (AW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .set_done (s1_adv && s1_last_r),
    .clr_addr (clr_addr),
    .ctl      (ctl)
  );

  // ---- stage 1: count update and pair accumulation ----
  always_comb begin
    if (fwd_v_r) begin
      v_cnt = fwd_cnt_r;
    end else if (rd_v.epoch == ctl.epoch) begin
      v_cnt = rd_v.count;
    end else begin
      v_cnt = '0;
    end
    if (fwd_c_r) begin
      c_cnt = fwd_cnt_r;
    end else if (rd_c.epoch == ctl.epoch) begin
      c_cnt = rd_c.count;
    end else begin
      c_cnt = '0;
    end
    if (!s1_c_ok_r) begin
      c_cnt = '0;
    end
  end

  assign new_cnt = (v_cnt == CNT_MAX) ? v_cnt : v_cnt + 1'b1;
  assign sum     = {1'b0, total_r} + (TOTAL_W + 1)'(c_cnt);
  assign tot_new = (sum > (TOTAL_W + 1)'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];

  always_comb begin
    if (ctl.clearing) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = clr_addr;
      mem_wr_data = '0;
    end else begin
      mem_wr_en         = s1_wr;
      mem_wr_addr       = s1_v_addr_r;
      mem_wr_data.epoch = ctl.epoch;
      mem_wr_data.count = new_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else if (s1_adv) begin
      total_r <= s1_last_r ? '0 : tot_new;
    end
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (out_valid_r && out_stall) || (s1_adv && s1_last_r);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      out_pair_count_r <= tot_new;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pair_count = out_pair_count_r;

  // ---- assertions ----
  a_no_update_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.clearing && s1_valid_r))
    else $error("pipeline active during histogram sweep");

  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(s1_adv && s1_last_r))
    else $error("result appeared without a last element");

  a_total_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_last_r) |=> (total_r == '0))
    else $error("running total not cleared after set end");

  a_no_accept_before_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_last_r && (ctl.epoch == EPOCH_MAX)) |-> !in_acc)
    else $error("element accepted ahead of epoch wrap sweep");

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// tb: self-checking testbench for pair_sum_counter, with a directed table and
// random sets checked against a built-in pair count predictor.
// Depends on psc_pkg and the pair_sum_counter RTL.
module tb;
  import psc_pkg::*;

  localparam int  VALUE_RANGE    = 1024;
  localparam int  RAND_ITEMS     = 640;
  localparam int  SETS_PER_TGT   = 12;    // random sets between target_sum writes
  localparam int  HOLD_CYCLES    = 300;   // long out_stall stretch in the last phase
  localparam int  SETTLE_CYCLES  = 8;     // pipeline flush before a cfg write
  localparam int  DRAIN_CYCLES   = 20;    // quiet time after the last count
  localparam int  MAX_REPORTS    = 40;
  localparam time LIMIT_NS       = 5_000_000;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [TGT_W-1:0]     cfg_wr_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [VAL_W-1:0]     in_value;
  logic                 in_last;
  logic                 out_valid;
  logic                 out_stall;
  logic [TOTAL_W-1:0]   out_pair_count;

  pair_sum_counter #(
    .VALUE_RANGE (VALUE_RANGE)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_value       (in_value),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pair_count (out_pair_count)
  );

  // ---------------------------------------------------------------------------
  // Pair count predictor: its own histogram, running total and target.
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0]   tally [VALUE_RANGE];
  logic [TOTAL_W-1:0] pair_total;
  logic [TGT_W-1:0]   tgt_model;

  // Pair counts still owed by the DUT, oldest first.
  logic [TOTAL_W-1:0] expected_counts [$];
  logic [TOTAL_W-1:0] want_count;

  int errors     = 0;
  int n_items    = 0;
  int n_sets     = 0;
  int n_checked  = 0;
  int n_targets  = 0;

  // Idle percentages, changed per phase by the stimulus process.
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;

  // Long hold-off handshake: stimulus bumps hold_reqs, receiver follows.
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;

  // Advance the model by one element; returns 1 when the set closes.
  function automatic bit count_pairs_step(input logic [VAL_W-1:0] v, input bit lst,
                                          output logic [TOTAL_W-1:0] cnt);
    logic [TGT_W-1:0]   comp;
    logic [TOTAL_W:0]   sum;
    cnt = '0;
    // complement below zero: skip lookup entirely
    if (tgt_model >= {1'b0, v}) begin
      comp = tgt_model - TGT_W'(v);
      // complement of zero counts; at or above the range it does not
      if (comp < VALUE_RANGE) begin
        sum        = pair_total + tally[comp[VAL_W-1:0]];
        pair_total = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[TOTAL_W-1:0];
      end
    end
    // count after lookup so an element never pairs with itself; saturating
    if (tally[v] != CNT_MAX) tally[v] = tally[v] + 1'b1;
    if (lst) begin
      cnt        = pair_total;
      pair_total = '0;
      foreach (tally[i]) tally[i] = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("%0t: timeout, %0d pair counts still outstanding", $time,
             expected_counts.size());
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: random or long out_stall, changed on the falling edge.
  // ---------------------------------------------------------------------------
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < rcv_idle_pct);
      end
    end
  end

  // Compare each accepted pair count against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_counts.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected transaction, expected none actual %0d",
                   $time, out_pair_count);
      end else begin
        want_count = expected_counts.pop_front();
        n_checked++;
        if (out_pair_count !== want_count) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: pair_count mismatch, expected %0d actual %0d",
                     $time, want_count, out_pair_count);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side. Tasks are entered and left on a falling edge.
  // ---------------------------------------------------------------------------

  // Offer one element, hold it until accepted, then log its expectation.
  // A typed count, where given, replaces the predicted one.
  task automatic send_item(input logic [VAL_W-1:0] v, input bit lst,
                           input bit typed, input logic [TOTAL_W-1:0] typed_count);
    logic [TOTAL_W-1:0] predicted;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    in_last  <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_items++;
    if (count_pairs_step(v, lst, predicted)) begin
      expected_counts.push_back(typed ? typed_count : predicted);
      n_sets++;
    end
    @(negedge clk);
  endtask

  // target_sum is only written with the block idle: all counts back, the
  // pipeline flushed and no histogram sweep running.
  task automatic load_target(input logic [TGT_W-1:0] t);
    in_valid <= 1'b0;
    while (expected_counts.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    while (in_stall) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= t;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    tgt_model   = t;
    n_targets++;
  endtask

  // Mostly random targets, with the extremes and the all-ones code mixed in.
  function automatic logic [TGT_W-1:0] pick_target();
    case ($urandom_range(9))
      0: return '0;
      1: return TGT_W'(2046);
      2: return '1;
      3: return TGT_W'(VALUE_RANGE - 1);
      default: return TGT_W'($urandom_range(0, 2046));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table. A row writes target_sum first when new_tgt is set, then
  // sends reps copies of value; last marks only the final copy. Rows with
  // typed set carry a hand-computed count, the rest use the predictor.
  // ---------------------------------------------------------------------------
  typedef struct {
    bit                 new_tgt;
    logic [TGT_W-1:0]   tgt;
    logic [VAL_W-1:0]   value;
    bit                 last;
    int                 reps;
    bit                 typed;
    logic [TOTAL_W-1:0] exp_count;
  } dir_row_t;

  dir_row_t dir_rows [19] = '{
    // target 0 straight out of reset
    '{1'b0, 11'd0,    10'd0,     1'b1, 1,    1'b1, 19'd0},  // lone element
    '{1'b0, 11'd0,    10'd0,     1'b1, 3,    1'b1, 19'd3},  // zero complement
    '{1'b0, 11'd0,    10'd1023,  1'b1, 1,    1'b1, 19'd0},  // target below value
    // top of the usable range
    '{1'b1, 11'd2046, 10'd1023,  1'b1, 2,    1'b1, 19'd1},
    '{1'b0, 11'd2046, 10'd0,     1'b0, 1,    1'b0, 19'd0},  // complement too big
    '{1'b0, 11'd2046, 10'd1023,  1'b1, 1,    1'b1, 19'd0},
    // complement of zero in a mixed set
    '{1'b1, 11'd1023, 10'd0,     1'b0, 1,    1'b0, 19'd0},
    '{1'b0, 11'd1023, 10'd1023,  1'b1, 2,    1'b1, 19'd2},
    '{1'b0, 11'd1023, 10'h2AA,   1'b0, 1,    1'b0, 19'd0},
    '{1'b0, 11'd1023, 10'h155,   1'b1, 1,    1'b1, 19'd1},
    '{1'b0, 11'd1023, 10'd512,   1'b0, 1,    1'b0, 19'd0},
    '{1'b0, 11'd1023, 10'd511,   1'b1, 1,    1'b1, 19'd1},
    // all-ones target: every complement is out of range
    '{1'b1, 11'd2047, 10'd1023,  1'b1, 2,    1'b1, 19'd0},
    '{1'b1, 11'd1024, 10'd0,     1'b0, 1,    1'b0, 19'd0},
    '{1'b1, 11'd1024, 10'd512,   1'b1, 2,    1'b1, 19'd1},
    // long set of zeros: running total saturates
    '{1'b1, 11'd0,    10'd0,     1'b1, 1030, 1'b1, TOTAL_MAX},
    '{1'b0, 11'd0,    10'd0,     1'b1, 1,    1'b1, 19'd0},  // cleared afterwards
    '{1'b1, 11'd700,  10'd300,   1'b0, 3,    1'b0, 19'd0},
    '{1'b0, 11'd700,  10'd400,   1'b1, 2,    1'b0, 19'd0}
  };

  // ---------------------------------------------------------------------------
  // Main stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int                 phase_items;
    int                 sets_here;
    int                 len;
    int                 npool;
    logic [VAL_W-1:0]   pool [3];
    int                 lo;
    int                 hi;
    logic [VAL_W-1:0]   v;
    bit                 paired;

    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    in_value    = '0;
    in_last     = 1'b0;
    pair_total  = '0;
    tgt_model   = '0;
    foreach (tally[i]) tally[i] = '0;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // the first idle mix also covers the directed rows
    snd_idle_pct = 19;
    rcv_idle_pct = 57;
    foreach (dir_rows[r]) begin
      if (dir_rows[r].new_tgt) load_target(dir_rows[r].tgt);
      for (int k = 0; k < dir_rows[r].reps; k++)
        send_item(dir_rows[r].value, dir_rows[r].last && (k == dir_rows[r].reps - 1),
                  dir_rows[r].typed, dir_rows[r].exp_count);
    end

    // Random part in three phases of idling: sender light / receiver heavy,
    // then swapped, then none at all.
    for (int ph = 0; ph < 3; ph++) begin
      snd_idle_pct = (ph == 0) ? 19 : (ph == 1) ? 57 : 0;
      rcv_idle_pct = (ph == 0) ? 57 : (ph == 1) ? 19 : 0;
      phase_items  = 0;
      sets_here    = 0;
      load_target(pick_target());

      if (ph == 2) begin
        // Back-pressure: results pile up behind a long out_stall while
        // one-element sets keep coming, so in_stall must rise.
        hold_reqs++;
        repeat (48) begin
          send_item(VAL_W'($urandom_range(0, VALUE_RANGE - 1)), 1'b1, 1'b0, '0);
          phase_items++;
        end
      end

      while (phase_items < RAND_ITEMS / 3) begin
        if (sets_here == SETS_PER_TGT) begin
          load_target(pick_target());
          sets_here = 0;
        end
        // mostly short sets keep the epoch counter turning over
        len = ($urandom_range(31) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 3);
        // values that can actually pair under the current target
        lo = (tgt_model > VALUE_RANGE - 1) ? int'(tgt_model) - (VALUE_RANGE - 1) : 0;
        hi = (tgt_model < VALUE_RANGE - 1) ? int'(tgt_model) : VALUE_RANGE - 1;
        paired = ($urandom_range(3) != 0) && (lo <= hi);
        npool  = $urandom_range(1, 3);
        for (int p = 0; p < 3; p++) pool[p] = VAL_W'($urandom_range(lo, (lo <= hi) ? hi : lo));
        for (int k = 0; k < len; k++) begin
          if (paired) begin
            v = pool[$urandom_range(0, npool - 1)];
            if ($urandom_range(1)) v = VAL_W'(tgt_model - TGT_W'(v));
          end else begin
            v = VAL_W'($urandom_range(0, VALUE_RANGE - 1));
          end
          send_item(v, k == len - 1, 1'b0, '0);
        end
        phase_items += len;
        sets_here++;
      end
    end

    // drain, then give any stray output time to show up
    in_valid <= 1'b0;
    while (expected_counts.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d transactions in %0d sets under %0d target_sum writes;",
             n_items, n_sets, n_targets);
    $display("checked %0d pair counts incl. saturation and a long output hold-off.",
             n_checked);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
